// File: rtl/mfl_pkg.sv
// Shared constants, command codes and status bundle for the max-flow engine.
`default_nettype none

package mfl_pkg;

    localparam int MAX_NODES = 256;
    localparam int MAX_ARCS  = 2048;

    localparam int NUM_W  = 9;                     // node number field width
    localparam int CAP_W  = 31;                    // edge capacity field width
    localparam int FLOW_W = 41;                    // reported flow width
    localparam int TOT_W  = 42;                    // flow accumulator width
    localparam int RES_W  = 32;                    // arc residual width
    localparam int NODE_W = $clog2(MAX_NODES);     // node index width
    localparam int ARC_W  = $clog2(MAX_ARCS);      // arc index width
    localparam int LINK_W = ARC_W + 1;             // list link: arc index + 1, 0 ends
    localparam int CNT_W  = ARC_W + 1;             // arc count, holds MAX_ARCS
    localparam int PTR_W  = NODE_W + 1;            // queue / stack pointer, holds MAX_NODES
    localparam int LVL_W  = NODE_W + 1;            // level label
    localparam int CFG_W  = 1;                     // register index width

    localparam logic [CFG_W-1:0] CFG_SOURCE = 1'd0;
    localparam logic [CFG_W-1:0] CFG_SINK   = 1'd1;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_E_CHK,
        OP_E_RDU,
        OP_E_WRU,
        OP_E_RDV,
        OP_E_WRV,
        OP_B_INIT,
        OP_B_POP,
        OP_B_NODE,
        OP_B_HEAD,
        OP_B_ARC,
        OP_B_TGT,
        OP_B_TEST,
        OP_B_TRD,
        OP_F_INIT,
        OP_F_LOOK,
        OP_F_HEAD,
        OP_F_TEST,
        OP_F_END,
        OP_F_RET1,
        OP_F_RET2,
        OP_A_INIT,
        OP_A_MRD,
        OP_A_MRES,
        OP_A_MIN,
        OP_A2_INIT,
        OP_A2_RD,
        OP_A2_SUB,
        OP_A2_ADD,
        OP_A_DONE,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic node_ok;
        logic room;
        logic last;
        logic terms_ok;
        logic rd_lt_wr;
        logic a_zero;
        logic v_is_t;
        logic found;
        logic depth_zero;
        logic depth_full;
        logic i_lt_depth;
        logic t_reached;
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

// File: rtl/max_flow_level_graph.sv
// Top level of the max-flow engine: sequencer plus datapath.
//
//  channel   dir  handshake            contents
//  in        in   in_valid/in_ready    from_node, to_node, edge_capacity, last_edge
//  out       out  out_valid/out_ready  max_flow, edges_dropped
//  cfg       in   cfg_we               cfg_index, cfg_data (source_node, sink_node)
//
// An edge without last_edge is checked and then ignored or stored as two arcs; the
// node-list head memory port, read then written once per arc, paces the storing.
// A last edge adds the solve: per phase a BFS that scans the arcs of each node
// dequeued, then a depth-first search that tries arcs and steps forward (through
// ST_F_RET1 and ST_F_RET2 on a retreat) and updates each path arc on augmentation.
// Solve time depends on the graph.
// Reset clears the arc count, totals and all valid bits at once; no clearing pass.
// A finished result waits in the output register; new edges are taken meanwhile,
// and only the next solve's result delivery stalls until that result is transferred.
`default_nettype none

module max_flow_level_graph (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [mfl_pkg::NUM_W-1:0]    from_node,
    input  wire logic [mfl_pkg::NUM_W-1:0]    to_node,
    input  wire logic [mfl_pkg::CAP_W-1:0]    edge_capacity,
    input  wire logic                         last_edge,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [mfl_pkg::FLOW_W-1:0]   max_flow,
    output logic                              edges_dropped,
    input  wire logic                         cfg_we,
    input  wire logic [mfl_pkg::CFG_W-1:0]    cfg_index,
    input  wire logic [mfl_pkg::NUM_W-1:0]    cfg_data
);
    import mfl_pkg::*;

    cmd_t    cmd;
    status_t st;

    mfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    mfl_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .from_node     (from_node),
        .to_node       (to_node),
        .edge_capacity (edge_capacity),
        .last_edge     (last_edge),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .max_flow      (max_flow),
        .edges_dropped (edges_dropped)
    );

endmodule

`default_nettype wire

// File: rtl/mfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/mfl_ctrl.sv
// Sequencer for edge loading, level labelling, blocking flow and result delivery.
`default_nettype none

module mfl_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire mfl_pkg::status_t st,
    output mfl_pkg::cmd_t         cmd
);
    import mfl_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE, ST_E_CHK, ST_E_RDU, ST_E_WRU, ST_E_RDV, ST_E_WRV, ST_E_POST,
        ST_S_START, ST_B_INIT, ST_B_POP, ST_B_NODE, ST_B_HEAD, ST_B_ARC, ST_B_TGT,
        ST_B_TEST, ST_B_TRD, ST_B_TDEC, ST_F_INIT, ST_F_LOOP, ST_F_HEAD, ST_F_SCAN,
        ST_F_TGT, ST_F_TEST, ST_F_END, ST_F_RET1, ST_F_RET2, ST_A_INIT, ST_A_MIN,
        ST_A_MRES, ST_A_MIN2, ST_A2_INIT, ST_A2, ST_A2_RES, ST_A2_SUB, ST_A2_ADD,
        ST_S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NOP;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_ACCEPT;
                    state_next = ST_E_CHK;
                end
            end
            ST_E_CHK:
            begin
                cmd.op     = OP_E_CHK;
                state_next = (st.node_ok && st.room) ? ST_E_RDU : ST_E_POST;
            end
            ST_E_RDU:
            begin
                cmd.op     = OP_E_RDU;
                state_next = ST_E_WRU;
            end
            ST_E_WRU:
            begin
                cmd.op     = OP_E_WRU;
                state_next = ST_E_RDV;
            end
            ST_E_RDV:
            begin
                cmd.op     = OP_E_RDV;
                state_next = ST_E_WRV;
            end
            ST_E_WRV:
            begin
                cmd.op     = OP_E_WRV;
                state_next = ST_E_POST;
            end
            ST_E_POST:  state_next = st.last ? ST_S_START : ST_IDLE;
            ST_S_START: state_next = st.terms_ok ? ST_B_INIT : ST_S_OUT;
            ST_B_INIT:
            begin
                cmd.op     = OP_B_INIT;
                state_next = ST_B_POP;
            end
            ST_B_POP:
            begin
                if (st.rd_lt_wr)
                begin
                    cmd.op     = OP_B_POP;
                    state_next = ST_B_NODE;
                end
                else
                begin
                    state_next = ST_B_TRD;
                end
            end
            ST_B_NODE:
            begin
                cmd.op     = OP_B_NODE;
                state_next = ST_B_HEAD;
            end
            ST_B_HEAD:
            begin
                cmd.op     = OP_B_HEAD;
                state_next = ST_B_ARC;
            end
            ST_B_ARC:
            begin
                if (st.a_zero)
                begin
                    state_next = ST_B_POP;
                end
                else
                begin
                    cmd.op     = OP_B_ARC;
                    state_next = ST_B_TGT;
                end
            end
            ST_B_TGT:
            begin
                cmd.op     = OP_B_TGT;
                state_next = ST_B_TEST;
            end
            ST_B_TEST:
            begin
                cmd.op     = OP_B_TEST;
                state_next = ST_B_ARC;
            end
            ST_B_TRD:
            begin
                cmd.op     = OP_B_TRD;
                state_next = ST_B_TDEC;
            end
            ST_B_TDEC:  state_next = st.t_reached ? ST_F_INIT : ST_S_OUT;
            ST_F_INIT:
            begin
                cmd.op     = OP_F_INIT;
                state_next = ST_F_LOOP;
            end
            ST_F_LOOP:
            begin
                if (st.v_is_t)
                begin
                    state_next = ST_A_INIT;
                end
                else
                begin
                    cmd.op     = OP_F_LOOK;
                    state_next = ST_F_HEAD;
                end
            end
            ST_F_HEAD:
            begin
                cmd.op     = OP_F_HEAD;
                state_next = ST_F_SCAN;
            end
            ST_F_SCAN:
            begin
                if (st.a_zero)
                begin
                    state_next = ST_F_END;
                end
                else
                begin
                    cmd.op     = OP_B_ARC;
                    state_next = ST_F_TGT;
                end
            end
            ST_F_TGT:
            begin
                cmd.op     = OP_B_TGT;
                state_next = ST_F_TEST;
            end
            ST_F_TEST:
            begin
                cmd.op     = OP_F_TEST;
                state_next = st.found ? ST_F_END : ST_F_SCAN;
            end
            ST_F_END:
            begin
                cmd.op = OP_F_END;
                if (!st.a_zero && !st.depth_full)
                begin
                    state_next = ST_F_LOOP;
                end
                else if (st.depth_zero)
                begin
                    state_next = ST_B_INIT;
                end
                else
                begin
                    state_next = ST_F_RET1;
                end
            end
            ST_F_RET1:
            begin
                cmd.op     = OP_F_RET1;
                state_next = ST_F_RET2;
            end
            ST_F_RET2:
            begin
                cmd.op     = OP_F_RET2;
                state_next = ST_F_LOOP;
            end
            ST_A_INIT:
            begin
                cmd.op     = OP_A_INIT;
                state_next = ST_A_MIN;
            end
            ST_A_MIN:
            begin
                if (st.i_lt_depth)
                begin
                    cmd.op     = OP_A_MRD;
                    state_next = ST_A_MRES;
                end
                else
                begin
                    state_next = ST_A2_INIT;
                end
            end
            ST_A_MRES:
            begin
                cmd.op     = OP_A_MRES;
                state_next = ST_A_MIN2;
            end
            ST_A_MIN2:
            begin
                cmd.op     = OP_A_MIN;
                state_next = ST_A_MIN;
            end
            ST_A2_INIT:
            begin
                cmd.op     = OP_A2_INIT;
                state_next = ST_A2;
            end
            ST_A2:
            begin
                if (st.i_lt_depth)
                begin
                    cmd.op     = OP_A2_RD;
                    state_next = ST_A2_RES;
                end
                else
                begin
                    cmd.op     = OP_A_DONE;
                    state_next = ST_F_LOOP;
                end
            end
            ST_A2_RES:
            begin
                cmd.op     = OP_A_MRES;
                state_next = ST_A2_SUB;
            end
            ST_A2_SUB:
            begin
                cmd.op     = OP_A2_SUB;
                state_next = ST_A2_ADD;
            end
            ST_A2_ADD:
            begin
                cmd.op     = OP_A2_ADD;
                state_next = ST_A2;
            end
            ST_S_OUT:
            begin
                // hold until the previous result has been transferred
                if (!st.out_busy)
                begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign in_ready = in_ready_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (state_reg == ST_IDLE))
        else $error("in_ready out of step with idle state");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_E_CHK))
        else $error("accepted edge not processed");

    a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_S_OUT && st.out_busy) |=> (state_reg == ST_S_OUT))
        else $error("result stage left while output busy");

endmodule

`default_nettype wire

// File: rtl/mfl_dp.sv
// Graph storage, queue, path stack, counters and flow arithmetic.
`default_nettype none

module mfl_dp (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire mfl_pkg::cmd_t                cmd,
    output mfl_pkg::status_t                  st,
    input  wire logic                         cfg_we,
    input  wire logic [mfl_pkg::CFG_W-1:0]    cfg_index,
    input  wire logic [mfl_pkg::NUM_W-1:0]    cfg_data,
    input  wire logic [mfl_pkg::NUM_W-1:0]    from_node,
    input  wire logic [mfl_pkg::NUM_W-1:0]    to_node,
    input  wire logic [mfl_pkg::CAP_W-1:0]    edge_capacity,
    input  wire logic                         last_edge,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [mfl_pkg::FLOW_W-1:0]   max_flow,
    output logic                              edges_dropped
);
    import mfl_pkg::*;

    // control state
    logic [NUM_W-1:0]     src_reg, snk_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 ovf_reg;
    logic [TOT_W-1:0]     tot_reg;
    logic [PTR_W-1:0]     rd_reg, wr_reg, depth_reg, i_reg;
    logic [MAX_NODES-1:0] head_vld_reg, lvl_vld_reg, cur_vld_reg;
    logic                 out_valid_reg;

    // payload
    logic [NODE_W-1:0]    eu_reg, ev_reg, v_reg, w_reg;
    logic                 eok_reg, last_reg;
    logic [CAP_W-1:0]     cap_reg;
    logic [LINK_W-1:0]    a_reg, lnk_reg;
    logic [LVL_W-1:0]     lv_reg;
    logic [RES_W-1:0]     r_reg, b_reg;
    logic [ARC_W-1:0]     p_reg;
    logic                 hvq_reg, lvq_reg, cvq_reg;
    logic [FLOW_W-1:0]    flow_reg;
    logic                 drop_reg;

    // memory ports
    logic                 head_we, link_we, tgt_we, res_we, lvl_we, que_we, stk_we, cur_we;
    logic [NODE_W-1:0]    head_wa, head_ra, lvl_wa, lvl_ra, que_wa, que_ra;
    logic [NODE_W-1:0]    stk_wa, stk_ra, cur_wa, cur_ra;
    logic [ARC_W-1:0]     arc_wa, res_wa, arc_ra, res_ra;
    logic [LINK_W-1:0]    head_wd, head_rd, link_rd, cur_wd, cur_rd;
    logic [NODE_W-1:0]    tgt_wd, tgt_rd, que_wd, que_rd;
    logic [RES_W-1:0]     res_wd, res_rd;
    logic [LVL_W-1:0]     lvl_wd, lvl_rd;
    logic [ARC_W-1:0]     stk_wd, stk_rd;

    logic [NODE_W-1:0]    s_idx, t_idx;
    logic [LINK_W-1:0]    head_val;
    logic [LVL_W-1:0]     lvl_val;
    logic [ARC_W-1:0]     a_arc;
    logic [PTR_W-1:0]     depth_dec;
    logic                 advance;

    assign s_idx     = NODE_W'(src_reg - NUM_W'(1));
    assign t_idx     = NODE_W'(snk_reg - NUM_W'(1));
    assign head_val  = hvq_reg ? head_rd : '0;
    assign lvl_val   = lvq_reg ? lvl_rd : '0;
    assign a_arc     = ARC_W'(a_reg - LINK_W'(1));
    assign depth_dec = depth_reg - PTR_W'(1);
    assign advance   = (a_reg != '0) && (depth_reg < PTR_W'(MAX_NODES));

    always_comb
    begin
        st.node_ok    = eok_reg;
        st.room       = (cnt_reg <= CNT_W'(MAX_ARCS - 2));
        st.last       = last_reg;
        st.terms_ok   = (src_reg != '0) && (src_reg <= NUM_W'(MAX_NODES)) &&
                        (snk_reg != '0) && (snk_reg <= NUM_W'(MAX_NODES)) &&
                        (src_reg != snk_reg);
        st.rd_lt_wr   = (rd_reg < wr_reg);
        st.a_zero     = (a_reg == '0);
        st.v_is_t     = (v_reg == t_idx);
        st.found      = (r_reg != '0) &&
                        ((LVL_W+1)'(lvl_val) == (LVL_W+1)'(lv_reg) + (LVL_W+1)'(1));
        st.depth_zero = (depth_reg == '0);
        st.depth_full = (depth_reg >= PTR_W'(MAX_NODES));
        st.i_lt_depth = (i_reg < depth_reg);
        st.t_reached  = (lvl_val != '0);
        st.out_busy   = out_valid_reg && !out_ready;
    end

    // memory addressing per command
    always_comb
    begin
        head_we = 1'b0; head_wa = eu_reg; head_wd = LINK_W'(cnt_reg + CNT_W'(1));
        head_ra = v_reg;
        link_we = 1'b0; tgt_we = 1'b0; arc_wa = cnt_reg[ARC_W-1:0]; tgt_wd = ev_reg;
        arc_ra  = a_arc;
        res_we  = 1'b0; res_wa = cnt_reg[ARC_W-1:0]; res_wd = RES_W'(cap_reg);
        res_ra  = a_arc;
        lvl_we  = 1'b0; lvl_wa = v_reg; lvl_wd = '0; lvl_ra = v_reg;
        que_we  = 1'b0; que_wa = wr_reg[NODE_W-1:0]; que_wd = w_reg;
        que_ra  = rd_reg[NODE_W-1:0];
        stk_we  = 1'b0; stk_wa = depth_reg[NODE_W-1:0]; stk_wd = a_arc;
        stk_ra  = i_reg[NODE_W-1:0];
        cur_we  = 1'b0; cur_wa = v_reg; cur_wd = a_reg; cur_ra = v_reg;
        case (cmd.op)
            OP_E_RDU: head_ra = eu_reg;
            OP_E_WRU:
            begin
                head_we = 1'b1;
                link_we = 1'b1;
                tgt_we  = 1'b1;
                res_we  = 1'b1;
            end
            OP_E_RDV: head_ra = ev_reg;
            OP_E_WRV:
            begin
                head_we = 1'b1;
                head_wa = ev_reg;
                link_we = 1'b1;
                tgt_we  = 1'b1;
                tgt_wd  = eu_reg;
                res_we  = 1'b1;
                res_wd  = '0;
            end
            OP_B_INIT:
            begin
                lvl_we = 1'b1;
                lvl_wa = s_idx;
                lvl_wd = LVL_W'(1);
                que_we = 1'b1;
                que_wa = '0;
                que_wd = s_idx;
            end
            OP_B_NODE:
            begin
                head_ra = que_rd;
                lvl_ra  = que_rd;
            end
            OP_B_TGT:  lvl_ra = tgt_rd;
            OP_B_TEST:
            begin
                if (lvl_val == '0 && r_reg != '0 && wr_reg < PTR_W'(MAX_NODES))
                begin
                    lvl_we = 1'b1;
                    lvl_wa = w_reg;
                    lvl_wd = lv_reg + LVL_W'(1);
                    que_we = 1'b1;
                end
            end
            OP_B_TRD:  lvl_ra = t_idx;
            OP_F_END:
            begin
                cur_we = 1'b1;
                if (advance)
                begin
                    stk_we = 1'b1;
                end
                else if (depth_reg != '0)
                begin
                    // dead end: drop the node from this phase and step back
                    lvl_we = 1'b1;
                    stk_ra = depth_dec[NODE_W-1:0];
                end
            end
            OP_F_RET1: arc_ra = {stk_rd[ARC_W-1:1], ~stk_rd[0]};
            OP_A_MRES: res_ra = stk_rd;
            OP_A2_SUB:
            begin
                res_we = 1'b1;
                res_wa = p_reg;
                res_wd = res_rd - b_reg;
                res_ra = {p_reg[ARC_W-1:1], ~p_reg[0]};
            end
            OP_A2_ADD:
            begin
                res_we = 1'b1;
                res_wa = {p_reg[ARC_W-1:1], ~p_reg[0]};
                res_wd = res_rd + b_reg;
            end
            default: ;
        endcase
    end

    mfl_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_head (
        .clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd),
        .raddr(head_ra), .rdata(head_rd));
    mfl_ram #(.WIDTH(LINK_W), .DEPTH(MAX_ARCS)) u_link (
        .clk(clk), .we(link_we), .waddr(arc_wa), .wdata(head_val),
        .raddr(arc_ra), .rdata(link_rd));
    mfl_ram #(.WIDTH(NODE_W), .DEPTH(MAX_ARCS)) u_tgt (
        .clk(clk), .we(tgt_we), .waddr(arc_wa), .wdata(tgt_wd),
        .raddr(arc_ra), .rdata(tgt_rd));
    mfl_ram #(.WIDTH(RES_W), .DEPTH(MAX_ARCS)) u_res (
        .clk(clk), .we(res_we), .waddr(res_wa), .wdata(res_wd),
        .raddr(res_ra), .rdata(res_rd));
    mfl_ram #(.WIDTH(LVL_W), .DEPTH(MAX_NODES)) u_lvl (
        .clk(clk), .we(lvl_we), .waddr(lvl_wa), .wdata(lvl_wd),
        .raddr(lvl_ra), .rdata(lvl_rd));
    mfl_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_que (
        .clk(clk), .we(que_we), .waddr(que_wa), .wdata(que_wd),
        .raddr(que_ra), .rdata(que_rd));
    mfl_ram #(.WIDTH(ARC_W), .DEPTH(MAX_NODES)) u_stk (
        .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
        .raddr(stk_ra), .rdata(stk_rd));
    mfl_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_cur (
        .clk(clk), .we(cur_we), .waddr(cur_wa), .wdata(cur_wd),
        .raddr(cur_ra), .rdata(cur_rd));

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg       <= NUM_W'(1);
            snk_reg       <= NUM_W'(2);
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            tot_reg       <= '0;
            rd_reg        <= '0;
            wr_reg        <= '0;
            depth_reg     <= '0;
            i_reg         <= '0;
            head_vld_reg  <= '0;
            lvl_vld_reg   <= '0;
            cur_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_SOURCE)
                begin
                    src_reg <= cfg_data;
                end
                else if (cfg_index == CFG_SINK)
                begin
                    snk_reg <= cfg_data;
                end
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (head_we)
            begin
                head_vld_reg[head_wa] <= 1'b1;
            end
            if (cur_we)
            begin
                cur_vld_reg[cur_wa] <= 1'b1;
            end
            if (lvl_we)
            begin
                lvl_vld_reg[lvl_wa] <= 1'b1;
            end
            if (que_we && cmd.op == OP_B_TEST)
            begin
                wr_reg <= wr_reg + PTR_W'(1);
            end
            case (cmd.op)
                OP_E_CHK:
                begin
                    if (eok_reg && !st.room)
                    begin
                        ovf_reg <= 1'b1;
                    end
                end
                OP_E_WRU, OP_E_WRV: cnt_reg <= cnt_reg + CNT_W'(1);
                OP_B_INIT:
                begin
                    lvl_vld_reg        <= '0;
                    lvl_vld_reg[s_idx] <= 1'b1;
                    rd_reg             <= '0;
                    wr_reg             <= PTR_W'(1);
                end
                OP_B_POP:  rd_reg <= rd_reg + PTR_W'(1);
                OP_F_INIT:
                begin
                    cur_vld_reg <= '0;
                    depth_reg   <= '0;
                end
                OP_F_END:
                begin
                    if (advance)
                    begin
                        depth_reg <= depth_reg + PTR_W'(1);
                    end
                    else if (depth_reg != '0)
                    begin
                        depth_reg <= depth_dec;
                    end
                end
                OP_A_INIT: i_reg <= '0;
                OP_A_MIN:  i_reg <= i_reg + PTR_W'(1);
                OP_A2_INIT:
                begin
                    i_reg   <= '0;
                    tot_reg <= tot_reg + TOT_W'(b_reg);
                end
                OP_A2_ADD: i_reg <= i_reg + PTR_W'(1);
                OP_A_DONE: depth_reg <= '0;
                OP_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    head_vld_reg  <= '0;
                    cnt_reg       <= '0;
                    ovf_reg       <= 1'b0;
                    tot_reg       <= '0;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hvq_reg <= head_vld_reg[head_ra];
        lvq_reg <= lvl_vld_reg[lvl_ra];
        cvq_reg <= cur_vld_reg[cur_ra];
        case (cmd.op)
            OP_ACCEPT:
            begin
                eu_reg   <= NODE_W'(from_node - NUM_W'(1));
                ev_reg   <= NODE_W'(to_node - NUM_W'(1));
                eok_reg  <= (from_node != '0) && (from_node <= NUM_W'(MAX_NODES)) &&
                            (to_node != '0) && (to_node <= NUM_W'(MAX_NODES));
                cap_reg  <= edge_capacity;
                last_reg <= last_edge;
            end
            OP_B_NODE: v_reg <= que_rd;
            OP_B_HEAD:
            begin
                a_reg  <= head_val;
                lv_reg <= lvl_val;
            end
            OP_B_TGT:
            begin
                w_reg   <= tgt_rd;
                r_reg   <= res_rd;
                lnk_reg <= link_rd;
            end
            OP_B_TEST: a_reg <= lnk_reg;
            OP_F_INIT: v_reg <= s_idx;
            OP_F_HEAD:
            begin
                a_reg  <= cvq_reg ? cur_rd : head_val;
                lv_reg <= lvl_val;
            end
            OP_F_TEST:
            begin
                if (!st.found)
                begin
                    a_reg <= lnk_reg;
                end
            end
            OP_F_END:
            begin
                if (advance)
                begin
                    v_reg <= w_reg;
                end
            end
            OP_F_RET2: v_reg <= tgt_rd;
            OP_A_INIT: b_reg <= '1;
            OP_A_MRES: p_reg <= stk_rd;
            OP_A_MIN:
            begin
                if (res_rd < b_reg)
                begin
                    b_reg <= res_rd;
                end
            end
            OP_A_DONE: v_reg <= s_idx;
            OP_OUT:
            begin
                flow_reg <= tot_reg[FLOW_W-1:0];
                drop_reg <= ovf_reg;
            end
            default: ;
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign max_flow      = flow_reg;
    assign edges_dropped = drop_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_ARCS))
        else $error("arc count beyond storage");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= PTR_W'(MAX_NODES))
        else $error("path depth beyond stack");

    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_reg <= wr_reg) && (wr_reg <= PTR_W'(MAX_NODES)))
        else $error("visit queue pointers inconsistent");

endmodule

`default_nettype wire

// File: sim/max_flow_level_graph_test.sv
// Self-checking testbench for the max-flow engine: edge graphs in, max-flow totals out.
`timescale 1ns / 1ps

module max_flow_level_graph_test;
    import mfl_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE = 20;
    localparam logic [CAP_W-1:0] CAP_MAX = {CAP_W{1'b1}};

    typedef struct {
        logic [NUM_W-1:0] from_node;
        logic [NUM_W-1:0] to_node;
        logic [CAP_W-1:0] cap;
        logic             last;
    } edge_item_t;

    typedef struct {
        logic [FLOW_W-1:0] flow;
        logic              dropped;
    } flow_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [NUM_W-1:0] from_node = '0;
    logic [NUM_W-1:0] to_node = '0;
    logic [CAP_W-1:0] edge_capacity = '0;
    logic last_edge = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [FLOW_W-1:0] max_flow;
    logic edges_dropped;
    logic cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_index = CFG_SOURCE;
    logic [NUM_W-1:0] cfg_data = '0;

    edge_item_t edge_queue[$];
    flow_result_t flow_expect[$];
    int error_count = 0;
    int cycle_count = 0;
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;
    int send_gap = 0;
    int recv_gap = 0;

    // predictor state
    logic [NUM_W-1:0] src_reg = 9'd1;
    logic [NUM_W-1:0] snk_reg = 9'd2;
    int arc_n = 0;
    bit overflow_flag = 1'b0;
    int arc_tail[MAX_ARCS];
    int arc_dest[MAX_ARCS];
    longint arc_res[MAX_ARCS];

    max_flow_level_graph uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .from_node(from_node), .to_node(to_node),
        .edge_capacity(edge_capacity), .last_edge(last_edge),
        .out_valid(out_valid), .out_ready(out_ready),
        .max_flow(max_flow), .edges_dropped(edges_dropped),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // augmenting shortest paths; the max-flow value does not depend on the method
    function automatic longint solve_flow();
        int prev_arc[MAX_NODES];
        int q[$];
        int s, t, v, w, k;
        bit found;
        longint b, total;
        if (src_reg < 1 || src_reg > MAX_NODES || snk_reg < 1 || snk_reg > MAX_NODES
            || src_reg == snk_reg)
            return 0;
        s = src_reg - 1;
        t = snk_reg - 1;
        total = 0;
        while (1)
        begin
            foreach (prev_arc[i]) prev_arc[i] = -1;
            prev_arc[s] = -2;
            q = {s};
            found = 0;
            while (q.size() > 0 && !found)
            begin
                v = q.pop_front();
                for (k = 0; k < arc_n; k++)
                begin
                    w = arc_dest[k];
                    if (arc_tail[k] == v && arc_res[k] > 0 && prev_arc[w] == -1)
                    begin
                        prev_arc[w] = k;
                        if (w == t)
                        begin
                            found = 1;
                            break;
                        end
                        q.push_back(w);
                    end
                end
            end
            if (!found)
                break;
            b = 64'h7FFF_FFFF_FFFF_FFFF;
            for (v = t; v != s; v = arc_tail[prev_arc[v]])
                if (arc_res[prev_arc[v]] < b)
                    b = arc_res[prev_arc[v]];
            for (v = t; v != s; v = arc_tail[prev_arc[v]])
            begin
                arc_res[prev_arc[v]] -= b;
                arc_res[prev_arc[v] ^ 1] += b;
            end
            total += b;
        end
        return total;
    endfunction

    task automatic take_edge(input edge_item_t e);
        flow_result_t r;
        if (e.from_node >= 1 && e.from_node <= MAX_NODES &&
            e.to_node >= 1 && e.to_node <= MAX_NODES)
        begin
            if (arc_n + 2 <= MAX_ARCS)
            begin
                arc_tail[arc_n] = e.from_node - 1;
                arc_dest[arc_n] = e.to_node - 1;
                arc_res[arc_n] = e.cap;
                arc_tail[arc_n+1] = e.to_node - 1;
                arc_dest[arc_n+1] = e.from_node - 1;
                arc_res[arc_n+1] = 0;
                arc_n += 2;
            end
            else
                overflow_flag = 1'b1;
        end
        if (e.last)
        begin
            r.flow = solve_flow();
            r.dropped = overflow_flag;
            flow_expect.push_back(r);
            arc_n = 0;
            overflow_flag = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        edge_item_t e;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                e.from_node = from_node;
                e.to_node = to_node;
                e.cap = edge_capacity;
                e.last = last_edge;
                take_edge(e);
            end
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (edge_queue.size() > 0)
            begin
                e = edge_queue.pop_front();
                from_node <= e.from_node;
                to_node <= e.to_node;
                edge_capacity <= e.cap;
                last_edge <= e.last;
                in_valid <= 1'b1;
                if (idle_on && $urandom_range(0, 9) == 0)
                    send_gap = $urandom_range(1, 12);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        flow_result_t r;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (flow_expect.size() == 0)
                    report_mismatch("unexpected result max_flow", max_flow, 0);
                else
                begin
                    r = flow_expect.pop_front();
                    if (max_flow !== r.flow)
                        report_mismatch("max_flow", max_flow, r.flow);
                    if (edges_dropped !== r.dropped)
                        report_mismatch("edges_dropped", edges_dropped, r.dropped);
                end
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                recv_gap = 400;
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                recv_gap = $urandom_range(0, 11);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic queue_link(input int f, input int t, input logic [CAP_W-1:0] c,
                              input bit last);
        edge_item_t e;
        e.from_node = f;
        e.to_node = t;
        e.cap = c;
        e.last = last;
        edge_queue.push_back(e);
    endtask

    task automatic drain();
        while (edge_queue.size() > 0 || in_valid || flow_expect.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [NUM_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_SOURCE)
            src_reg = val;
        else
            snk_reg = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int pick_node(input int pool[6]);
        return pool[$urandom_range(0, 5)];
    endfunction

    function automatic logic [CAP_W-1:0] pick_cap();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return $urandom_range(0, 20);
        if (sel < 9)
            return $urandom() & CAP_MAX;
        return CAP_MAX;
    endfunction

    initial
    begin
        int sent, n_edges, graphs, pool[6];
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset terminals, zero capacity, out-of-range nodes
        queue_link(1, 2, CAP_MAX, 0);
        queue_link(1, 3, 0, 0);
        queue_link(3, 2, 5, 0);
        queue_link(0, 2, 9, 0);
        queue_link(257, 1, 9, 0);
        queue_link(511, 511, 9, 1);
        // flow over two paths joined by a cross arc
        queue_link(1, 3, 10, 0);
        queue_link(1, 4, 10, 0);
        queue_link(3, 4, 10, 0);
        queue_link(3, 2, 10, 0);
        queue_link(4, 2, 10, 1);
        queue_link(0, 0, 0, 1);
        drain();
        write_reg(CFG_SOURCE, 256);
        write_reg(CFG_SINK, 1);
        queue_link(256, 1, CAP_MAX, 0);
        queue_link(256, 1, CAP_MAX, 0);
        queue_link(1, 256, 3, 1);
        drain();
        write_reg(CFG_SINK, 256);
        queue_link(256, 256, 7, 1);
        drain();
        write_reg(CFG_SOURCE, 0);
        queue_link(1, 256, 7, 1);
        drain();
        write_reg(CFG_SOURCE, 1);
        write_reg(CFG_SINK, 300);
        queue_link(1, 300, 7, 1);
        drain();

        // fill arc storage with parallel arcs at full capacity, then overflow
        write_reg(CFG_SINK, 2);
        for (int i = 0; i < MAX_ARCS / 2; i++)
            queue_link(1, 2, CAP_MAX, 0);
        queue_link(1, 2, 5, 0);
        queue_link(1, 2, 4, 1);
        queue_link(1, 2, 3, 1);
        drain();

        // hold the output while more graphs arrive
        hold_req = 1'b1;
        for (int g = 0; g < 3; g++)
        begin
            queue_link(1, 3, g + 1, 0);
            queue_link(3, 2, 50, 0);
            queue_link(1, 2, 7, 1);
        end
        drain();

        sent = 0;
        graphs = 0;
        while (sent < 550)
        begin
            if (graphs % 6 == 0)
            begin
                drain();
                case ($urandom_range(0, 9))
                    0: write_reg(CFG_SOURCE, $urandom_range(0, 511));
                    1: write_reg(CFG_SOURCE, 256);
                    default: write_reg(CFG_SOURCE, $urandom_range(1, 8));
                endcase
                case ($urandom_range(0, 9))
                    0: write_reg(CFG_SINK, $urandom_range(0, 511));
                    1: write_reg(CFG_SINK, 256);
                    default: write_reg(CFG_SINK, $urandom_range(1, 8));
                endcase
            end
            if (sent > 450)
                idle_on = 1'b0;
            pool[0] = src_reg;
            pool[1] = snk_reg;
            for (int i = 2; i < 6; i++)
                pool[i] = $urandom_range(1, 8);
            n_edges = $urandom_range(1, 15);
            for (int i = 0; i < n_edges; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    queue_link($urandom_range(0, 511), $urandom_range(0, 511), pick_cap(),
                               i == n_edges - 1);
                else
                    queue_link(pick_node(pool), pick_node(pool), pick_cap(),
                               i == n_edges - 1);
            end
            sent += n_edges;
            graphs++;
        end

        while (edge_queue.size() > 0 || in_valid || flow_expect.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
